/* hdl/svfr_pkg.sv */
`default_nettype none
package svfr_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SETVOL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [6:0] VolMax = 7'h7f;

  // per-track fade record, one memory word
  typedef struct packed {
    logic        active;
    logic [1:0]  dir;
    logic [15:0] steps;
    logic [15:0] ticks;
    logic [15:0] period;
  } track_t;

  localparam int TrackW = $bits(track_t);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CALC  = 6'b001000,
    ST_CLEAR = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

endpackage
`default_nettype wire

/* hdl/svfr_if.sv */
`default_nettype none
interface svfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  sequence_index;
  logic [4:0]  track_index;
  logic signed [1:0]  fade_direction;
  logic signed [15:0] step_budget;
  logic signed [15:0] tick_budget;
  logic signed [15:0] fade_period;
  logic [6:0]  new_left_volume;
  logic [6:0]  new_right_volume;
  modport source (output valid, command, sequence_index, track_index, fade_direction,
                  step_budget, tick_budget, fade_period, new_left_volume,
                  new_right_volume, input ready);
  modport sink (input valid, command, sequence_index, track_index, fade_direction,
                step_budget, tick_budget, fade_period, new_left_volume,
                new_right_volume, output ready);
endinterface

interface svfr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] left_volume;
  logic [6:0] right_volume;
  logic       fade_running;
  modport source (output valid, left_volume, right_volume, fade_running, input ready);
  modport sink (input valid, left_volume, right_volume, fade_running, output ready);
endinterface
`default_nettype wire

/* hdl/svfr_ram.sv */
`default_nettype none
module svfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/sequence_volume_fade_ramp.sv */
// sequence_volume_fade_ramp: per-track linear volume fade
// in_req (svfr_in_if sink) carries one command per request: tick, start fade
// on a track, or set a sequence's left/right volume. out_req (svfr_out_if
// source) returns exactly one result per request: the sequence volume after
// the command and whether the addressed track still fades.
// one request is worked on at a time. start, set-volume, unused codes and
// ticks to idle tracks pass read and out; a tick on an active track passes
// read, div, calc and out, and with a positive period div forms the
// bit-serial remainder of the tick counter by the period.
// in_req is ready again the cycle after the result is taken.
// the track record and its active bit live in one synchronous ram
// (registered read); the sequence volumes sit in flip-flops.
// the result sits in an output register; while the receiver stalls the
// block holds it and accepts nothing new.
// reset (rst_ni low, asynchronous) sets every sequence volume to 127 and
// empties the output register; a clearing pass over all NUM_SEQUENCES *
// NUM_TRACKS slots (512 by default) then zeroes the ram, in_req not ready until done.
`default_nettype none
module sequence_volume_fade_ramp
  import svfr_pkg::*;
#(
  parameter int NUM_SEQUENCES = 16,
  parameter int NUM_TRACKS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  svfr_in_if.sink    in_req,
  svfr_out_if.source out_req
);
  localparam int Slots = NUM_SEQUENCES * NUM_TRACKS;
  localparam int SlotW = $clog2(Slots) > 0 ? $clog2(Slots) : 1;
  localparam int SeqW  = $clog2(NUM_SEQUENCES) > 0 ? $clog2(NUM_SEQUENCES) : 1;

  state_e state_q, state_d;

  // latched request
  logic [1:0]   cmd_q;
  logic         range_ok_q;
  logic [SlotW-1:0] slot_q;
  logic [SeqW-1:0]  sidx_q;
  track_t       start_q;
  logic [6:0]   nl_q, nr_q;
  // active bit of the addressed track after the request
  logic         run_q;

  logic [6:0]   vol_l_q [NUM_SEQUENCES];
  logic [6:0]   vol_r_q [NUM_SEQUENCES];

  // clearing pass address
  logic [SlotW-1:0] clr_q;

  // divider state: remainder of |new tick count| by period, restoring, one bit a cycle
  logic [15:0]  dividend_q;
  logic [16:0]  rem_q;
  logic [4:0]   bit_q;

  track_t       rd_rec;
  track_t       wr_rec;
  logic         wr_en;
  logic [SlotW-1:0] wr_addr, rd_addr, in_slot;
  logic [15:0]  new_ticks_q;
  logic [15:0]  ticks_dec;

  logic         out_valid_q;
  logic [6:0]   out_l_q, out_r_q;
  logic         out_run_q;

  assign in_slot = SlotW'(32'(in_req.sequence_index) * NUM_TRACKS +
                          32'(in_req.track_index));
  // look up the incoming slot while idle so the record is there in ST_READ
  assign rd_addr = (state_q == ST_IDLE) ? in_slot : slot_q;
  assign wr_addr = (state_q == ST_CLEAR) ? clr_q : slot_q;

  svfr_ram #(.Width(TrackW), .Depth(Slots)) u_track_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_rec),
    .raddr_i (rd_addr),
    .rdata_o (rd_rec)
  );

  logic accept;
  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_q == ST_IDLE) && !out_valid_q;

  logic is_tick_active;
  assign is_tick_active = range_ok_q && (cmd_q == CMD_TICK) && rd_rec.active;

  // tick arithmetic, from the record read and new tick count
  logic signed [15:0] p_s, steps_s;
  logic signed [1:0]  dir_s;
  logic signed [17:0] steps_n;
  logic signed [15:0] steps_w;
  logic signed [17:0] nvl, nvr;
  logic [6:0]   cur_l, cur_r, res_l, res_r;
  logic         stop, vol_wr, rem_zero;

  assign rem_zero = (rem_q[15:0] == 16'd0);

  always_comb begin
    p_s     = signed'(rd_rec.period);
    steps_s = signed'(rd_rec.steps);
    dir_s   = signed'(rd_rec.dir);
    cur_l   = vol_l_q[sidx_q];
    cur_r   = vol_r_q[sidx_q];
    steps_n = 18'(steps_s);
    nvl     = 18'(cur_l);
    nvr     = 18'(cur_r);
    res_l   = cur_l;
    res_r   = cur_r;
    stop    = 1'b0;
    vol_wr  = 1'b0;
    if (p_s > 0) begin
      if (dir_s > 0) steps_n = 18'(steps_s) - 18'sd1;
      else if (dir_s < 0) steps_n = 18'(steps_s) + 18'sd1;
      nvl = $signed({11'd0, cur_l}) + 18'sd1 * ((dir_s > 0) ? 18'sd1 : -18'sd1);
      nvr = $signed({11'd0, cur_r}) + ((dir_s > 0) ? 18'sd1 : -18'sd1);
    end else begin
      if (dir_s > 0) steps_n = 18'(steps_s) + 18'(p_s);
      else if (dir_s < 0) steps_n = 18'(steps_s) - 18'(p_s);
      nvl = (dir_s > 0) ? $signed({11'd0, cur_l}) - 18'(p_s)
                        : $signed({11'd0, cur_l}) + 18'(p_s);
      nvr = (dir_s > 0) ? $signed({11'd0, cur_r}) - 18'(p_s)
                        : $signed({11'd0, cur_r}) + 18'(p_s);
    end
    steps_w = steps_n[15:0];
    if (dir_s > 0) begin
      vol_wr = 1'b1;
      if (steps_w < 0 || nvl > 18'sd127 || nvr > 18'sd127) begin
        res_l = VolMax; res_r = VolMax; stop = 1'b1;
      end else begin
        res_l = nvl[6:0]; res_r = nvr[6:0];
      end
    end else if (dir_s < 0) begin
      vol_wr = 1'b1;
      if (steps_w > 0 || nvl < 18'sd0 || nvr < 18'sd0) begin
        res_l = 7'd0; res_r = 7'd0; stop = 1'b1;
      end else begin
        res_l = nvl[6:0]; res_r = nvr[6:0];
      end
    end
  end

  // positive period with nonzero remainder skips everything but the tick write
  logic skip;
  assign skip = (p_s > 0) && !rem_zero;

  // fade ends on saturation, tick counter at zero or steps used up
  logic fade_end;
  assign fade_end = !skip && (stop || new_ticks_q == 16'd0 || steps_w == 16'sd0);

  always_comb begin
    wr_en  = 1'b0;
    wr_rec = rd_rec;
    if (state_q == ST_CLEAR) begin
      wr_en  = 1'b1;
      wr_rec = '0;
    end else if (state_q == ST_READ && range_ok_q && cmd_q == CMD_START) begin
      wr_en  = 1'b1;
      wr_rec = start_q;
    end else if (state_q == ST_CALC) begin
      wr_en         = 1'b1;
      wr_rec.ticks  = new_ticks_q;
      if (!skip) wr_rec.steps = steps_w;
      wr_rec.active = !fade_end;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SlotW'(Slots - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_READ;
      ST_READ:  state_d = is_tick_active ? ST_DIV : ST_OUT;
      ST_DIV:   if (bit_q == 5'd0 || !(signed'(rd_rec.period) > 0)) state_d = ST_CALC;
      ST_CALC:  state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic [16:0] rem_sh;
  assign rem_sh = {rem_q[15:0], dividend_q[15]};

  assign ticks_dec = rd_rec.ticks - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SEQUENCES; i++) begin
        vol_l_q[i] <= VolMax;
        vol_r_q[i] <= VolMax;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + SlotW'(1);
      if (out_valid_q && out_req.ready) out_valid_q <= 1'b0;
      if (state_q == ST_READ && range_ok_q && cmd_q == CMD_SETVOL) begin
        vol_l_q[sidx_q] <= nl_q;
        vol_r_q[sidx_q] <= nr_q;
      end
      if (state_q == ST_CALC && !skip && vol_wr) begin
        vol_l_q[sidx_q] <= res_l;
        vol_r_q[sidx_q] <= res_r;
      end
      if (state_q == ST_OUT) begin
        out_valid_q <= 1'b1;
        out_l_q     <= range_ok_q ? vol_l_q[sidx_q] : 7'd0;
        out_r_q     <= range_ok_q ? vol_r_q[sidx_q] : 7'd0;
        out_run_q   <= run_q;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_req.command;
      range_ok_q <= (32'(in_req.sequence_index) < NUM_SEQUENCES) &&
                    (32'(in_req.track_index) < NUM_TRACKS);
      slot_q     <= in_slot;
      sidx_q     <= SeqW'(in_req.sequence_index);
      start_q    <= '{active: 1'b1, dir: in_req.fade_direction,
                      steps: in_req.step_budget, ticks: in_req.tick_budget,
                      period: in_req.fade_period};
      nl_q       <= in_req.new_left_volume;
      nr_q       <= in_req.new_right_volume;
    end
    if (state_q == ST_READ) begin
      bit_q <= 5'd16;
      rem_q <= '0;
      run_q <= range_ok_q && ((cmd_q == CMD_START) || rd_rec.active);
    end
    if (state_q == ST_CALC && fade_end) run_q <= 1'b0;
    if (state_q == ST_DIV) begin
      if (bit_q == 5'd16) begin
        // first cycle: form new tick count, load its magnitude
        new_ticks_q <= ticks_dec;
        dividend_q  <= ticks_dec[15] ? 16'(-ticks_dec) : ticks_dec;
        bit_q <= 5'd15;
      end else begin
        dividend_q <= {dividend_q[14:0], 1'b0};
        if (rem_sh >= {1'b0, rd_rec.period}) rem_q <= rem_sh - {1'b0, rd_rec.period};
        else rem_q <= rem_sh;
        bit_q <= bit_q - 5'd1;
      end
    end
  end

  assign out_req.valid        = out_valid_q;
  assign out_req.left_volume  = out_l_q;
  assign out_req.right_volume = out_r_q;
  assign out_req.fade_running = out_run_q;

endmodule
`default_nettype wire
